// ===== rtl/usage_color_wheel_led_mixer_macros.svh =====
// assertion macros shared by the mixer rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef USAGE_COLOR_WHEEL_LED_MIXER_MACROS_SVH
`define USAGE_COLOR_WHEEL_LED_MIXER_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define UCWLM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ucwlm assertion failed");

// next-cycle implication, disabled while reset is low
`define UCWLM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ucwlm assertion failed");

`endif

// ===== rtl/ucwlm_pkg.sv =====
// types and constants for the usage colour wheel led mixer
// no dependencies; imported by ucwlm_wheel, usage_color_wheel_led_mixer and the bench
package ucwlm_pkg;

    localparam int unsigned LVL_W     = 8;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_W     = 8;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_SPEED = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLEW_DELTA = 1'b1;

    localparam logic [CFG_W-1:0] IDLE_SPEED_RST = 8'd8;
    localparam logic [CFG_W-1:0] SLEW_DELTA_RST = 8'd1;

    localparam logic [LVL_W-1:0] LOAD_IDLE   = 8'd255;
    localparam logic [LVL_W-1:0] HUE_WRAP    = 8'd150;
    localparam logic [LVL_W-1:0] BAND_STEPS  = 8'd25;
    localparam logic [LVL_W-1:0] WHEEL_SLOPE = 8'd10;
    localparam logic [LVL_W-1:0] LVL_MAX     = 8'd255;

    typedef enum logic [1:0] {
        OP_SET_USAGE = 2'd0,
        OP_TICK      = 2'd1,
        OP_PWM       = 2'd2
    } t_opcode;

    typedef struct packed {
        t_opcode          opcode;
        logic [LVL_W-1:0] usage_value;
    } t_in_item;

    typedef struct packed {
        logic             red_on;
        logic             green_on;
        logic             blue_on;
        logic [LVL_W-1:0] red_level;
        logic [LVL_W-1:0] green_level;
        logic [LVL_W-1:0] blue_level;
    } t_out_item;

    // smoothed channel levels
    typedef struct packed {
        logic [LVL_W-1:0] red;
        logic [LVL_W-1:0] green;
        logic [LVL_W-1:0] blue;
    } t_levels;

    // usage and idle-rotation state touched by a tick
    typedef struct packed {
        logic [LVL_W-1:0] load_value;
        logic [LVL_W-1:0] silence_count;
        logic [LVL_W-1:0] idle_divider;
        logic [LVL_W-1:0] idle_hue;
    } t_tick_state;

endpackage

// ===== rtl/ucwlm_wheel.sv =====
// timer tick datapath: silence timeout, idle hue, colour wheel and slew
// depends on ucwlm_pkg
module ucwlm_wheel
    import ucwlm_pkg::*;
(
    input  t_tick_state      i_state,
    input  t_levels          i_levels,
    input  logic [CFG_W-1:0] i_idle_speed,
    input  logic [CFG_W-1:0] i_slew_delta,
    output t_tick_state      o_state,
    output t_levels          o_levels
);

    logic [LVL_W-1:0] sc_inc;
    logic [LVL_W-1:0] load_eff;
    logic             idle;
    logic [LVL_W-1:0] u;
    logic [LVL_W-1:0] div_inc;
    logic [LVL_W-1:0] hue_inc;
    logic [2:0]       band;
    logic [LVL_W-1:0] base;
    logic [LVL_W-1:0] offset;
    logic [LVL_W-1:0] ramp_up;
    logic [LVL_W-1:0] ramp_dn;
    t_levels          target;

    // step cur toward want by delta, landing on want when within reach
    function automatic logic [LVL_W-1:0] slew(
        input logic [LVL_W-1:0] cur,
        input logic [LVL_W-1:0] want,
        input logic [LVL_W-1:0] delta
    );
        logic [LVL_W-1:0] res;
        res = cur;
        if (cur > want) begin
            res = ((cur - want) <= delta) ? want : cur - delta;
        end else if (cur < want) begin
            res = ((want - cur) <= delta) ? want : cur + delta;
        end
        return res;
    endfunction

    always_comb begin
        sc_inc   = i_state.silence_count + 8'd1;
        load_eff = (sc_inc == '0) ? LOAD_IDLE : i_state.load_value;
        idle     = load_eff > HUE_WRAP;
        u        = idle ? i_state.idle_hue : load_eff;
        div_inc  = i_state.idle_divider + 8'd1;
        hue_inc  = i_state.idle_hue + 8'd1;

        o_state.load_value    = load_eff;
        o_state.silence_count = sc_inc;
        o_state.idle_divider  = i_state.idle_divider;
        o_state.idle_hue      = i_state.idle_hue;
        if (idle) begin
            if (div_inc >= i_idle_speed) begin
                o_state.idle_divider = '0;
                o_state.idle_hue     = (hue_inc >= HUE_WRAP) ? '0 : hue_inc;
            end else begin
                o_state.idle_divider = div_inc;
            end
        end
    end

    // band select, six bands of 25 steps
    always_comb begin
        if (u < BAND_STEPS) begin
            band = 3'd0;
        end else if (u < 8'(2 * BAND_STEPS)) begin
            band = 3'd1;
        end else if (u < 8'(3 * BAND_STEPS)) begin
            band = 3'd2;
        end else if (u < 8'(4 * BAND_STEPS)) begin
            band = 3'd3;
        end else if (u < 8'(5 * BAND_STEPS)) begin
            band = 3'd4;
        end else begin
            band = 3'd5;
        end
        base    = 8'(band * BAND_STEPS);
        offset  = u - base;
        // offset stays at or below 25, so the product fits in 8 bits
        ramp_up = 8'(offset * WHEEL_SLOPE);
        ramp_dn = LVL_MAX - ramp_up;
    end

    always_comb begin
        case (band)
            3'd0: begin
                target = '{red: '0, green: ramp_up, blue: LVL_MAX};
            end
            3'd1: begin
                target = '{red: '0, green: LVL_MAX, blue: ramp_dn};
            end
            3'd2: begin
                target = '{red: ramp_up, green: LVL_MAX, blue: '0};
            end
            3'd3: begin
                target = '{red: LVL_MAX, green: ramp_dn, blue: '0};
            end
            3'd4: begin
                target = '{red: LVL_MAX, green: '0, blue: ramp_up};
            end
            default: begin
                target = '{red: ramp_dn, green: '0, blue: LVL_MAX};
            end
        endcase
    end

    assign o_levels.red   = slew(i_levels.red,   target.red,   i_slew_delta);
    assign o_levels.green = slew(i_levels.green, target.green, i_slew_delta);
    assign o_levels.blue  = slew(i_levels.blue,  target.blue,  i_slew_delta);

endmodule

// ===== rtl/usage_color_wheel_led_mixer.sv =====
// top level of the usage colour wheel led mixer
// depends on ucwlm_pkg, ucwlm_wheel and usage_color_wheel_led_mixer_macros.svh
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-----------------------------
//  in      | to block  | i_in_valid / o_in_stall  | i_in_data   (t_in_item)
//  out     | from block| o_out_valid / i_out_stall| o_out_data  (t_out_item)
//  cfg     | to block  | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// one transaction per clock sustained while the result side does not stall; each one
// passes the input register, then the result register, with one tick datapath between
// i_rst_n is synchronous, active low; clears state, config and both valids
// a stalled result holds the result register; the input register still
// fills, so the upstream side stalls only when both registers are occupied
`include "usage_color_wheel_led_mixer_macros.svh"

module usage_color_wheel_led_mixer
    import ucwlm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input transactions
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    // result transactions
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    // configuration
    logic [CFG_W-1:0] r_idle_speed;
    logic [CFG_W-1:0] r_slew_delta;

    // input register
    logic             r_in_valid;
    t_in_item         r_in;

    // result register
    logic             r_out_valid;
    t_out_item        r_out;

    // architectural state
    t_tick_state      r_tick;
    t_tick_state      n_tick;
    t_levels          r_levels;
    t_levels          n_levels;
    logic [LVL_W-1:0] r_pwm_phase;
    logic [LVL_W-1:0] n_pwm_phase;
    t_out_item        n_out;

    // tick datapath outputs
    t_tick_state      tick_state;
    t_levels          tick_levels;

    logic             in_accept;
    logic             advance;

    // held item moves on when the result register is free or draining
    assign advance     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !advance;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    ucwlm_wheel u_wheel (
        .i_state      (r_tick),
        .i_levels     (r_levels),
        .i_idle_speed (r_idle_speed),
        .i_slew_delta (r_slew_delta),
        .o_state      (tick_state),
        .o_levels     (tick_levels)
    );

    // next state for the held transaction
    always_comb begin
        n_tick      = r_tick;
        n_levels    = r_levels;
        n_pwm_phase = r_pwm_phase;
        case (r_in.opcode)
            OP_SET_USAGE: begin
                n_tick.load_value    = r_in.usage_value;
                n_tick.silence_count = '0;
            end
            OP_TICK: begin
                n_tick   = tick_state;
                n_levels = tick_levels;
            end
            OP_PWM: begin
                n_pwm_phase = r_pwm_phase + 8'd1;
            end
            default: begin
                // unused opcode leaves state alone
            end
        endcase

        // pins compare the phase before any advance with the new levels
        n_out.red_on      = r_pwm_phase < n_levels.red;
        n_out.green_on    = r_pwm_phase < n_levels.green;
        n_out.blue_on     = r_pwm_phase < n_levels.blue;
        n_out.red_level   = n_levels.red;
        n_out.green_level = n_levels.green;
        n_out.blue_level  = n_levels.blue;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_speed <= IDLE_SPEED_RST;
            r_slew_delta <= SLEW_DELTA_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_IDLE_SPEED: r_idle_speed <= i_cfg_data;
                CFG_SLEW_DELTA: r_slew_delta <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // state, input register and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_tick      <= '{load_value: LOAD_IDLE, silence_count: '0,
                             idle_divider: '0, idle_hue: '0};
            r_levels    <= '0;
            r_pwm_phase <= '0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance) begin
                r_out_valid <= 1'b1;
                r_tick      <= n_tick;
                r_levels    <= n_levels;
                r_pwm_phase <= n_pwm_phase;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    // idle hue always stays inside the wheel
    `UCWLM_ASSERT_NOW(a_hue_range, i_clk, i_rst_n, 1'b1, r_tick.idle_hue < HUE_WRAP)

    // upstream stalls only when both registers are full and downstream stalls
    `UCWLM_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_in_stall,
        r_in_valid && r_out_valid && i_out_stall)

    // a transaction that moves on always lands in the result register
    `UCWLM_ASSERT_NEXT(a_result_lands, i_clk, i_rst_n, advance, r_out_valid)

    // pwm step advances the phase by exactly one
    `UCWLM_ASSERT_NEXT(a_pwm_step, i_clk, i_rst_n, advance && r_in.opcode == OP_PWM,
        r_pwm_phase == 8'($past(r_pwm_phase) + 8'd1))

    // set usage clears the silence counter
    `UCWLM_ASSERT_NEXT(a_usage_clear, i_clk, i_rst_n,
        advance && r_in.opcode == OP_SET_USAGE, r_tick.silence_count == '0)

endmodule

// ===== bench/led_mixer_checker.sv =====
// transaction checker for the usage colour wheel led mixer: watches all three channels,
// keeps its own copy of the mixer state and compares every result field by field
// depends on ucwlm_pkg
`timescale 1ns / 1ps

module led_mixer_checker
    import ucwlm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  t_in_item             i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  t_out_item            i_out_data,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_mismatches,
    output int                   o_pending,
    output int                   o_compared
);

    logic [CFG_W-1:0] speed_q;
    logic [CFG_W-1:0] delta_q;
    logic [LVL_W-1:0] load_q;
    logic [LVL_W-1:0] silence_q;
    logic [LVL_W-1:0] divider_q;
    logic [LVL_W-1:0] hue_q;
    logic [LVL_W-1:0] phase_q;
    t_levels          levels_q;

    // expected led drive, oldest first
    t_out_item led_drive_q[$];

    function automatic logic [LVL_W-1:0] approach_level(input logic [LVL_W-1:0] cur,
                                                        input logic [LVL_W-1:0] goal,
                                                        input logic [CFG_W-1:0] stp);
        if (cur > goal) begin
            return (cur - goal <= stp) ? goal : cur - stp;
        end
        if (cur < goal) begin
            return (goal - cur <= stp) ? goal : cur + stp;
        end
        return cur;
    endfunction

    task automatic check_field(input string name, input logic [LVL_W-1:0] want,
                               input logic [LVL_W-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            o_mismatches++;
        end
    endtask

    // apply one event to the local mixer state and form the led drive it yields
    task automatic advance_mixer(input t_in_item ev, output t_out_item res);
        logic [LVL_W-1:0] phase_seen;
        logic [LVL_W-1:0] hue_in;
        int               pos;
        t_levels          goal;
        phase_seen = phase_q;
        case (ev.opcode)
            OP_SET_USAGE: begin
                load_q    = ev.usage_value;
                silence_q = '0;
            end
            OP_TICK: begin
                silence_q = silence_q + 8'd1;
                if (silence_q == '0) load_q = LOAD_IDLE;
                hue_in = load_q;
                if (load_q > HUE_WRAP) begin
                    hue_in    = hue_q;
                    divider_q = divider_q + 8'd1;
                    if (divider_q >= speed_q) begin
                        divider_q = '0;
                        hue_q     = hue_q + 8'd1;
                        if (hue_q >= HUE_WRAP) hue_q = '0;
                    end
                end
                // six bands round the wheel, each a flat pair and one ramp
                pos = int'(hue_in);
                if (pos < int'(BAND_STEPS)) begin
                    goal.red   = '0;
                    goal.blue  = LVL_MAX;
                    goal.green = LVL_W'(pos * WHEEL_SLOPE);
                end else if (pos < 2 * BAND_STEPS) begin
                    goal.red   = '0;
                    goal.green = LVL_MAX;
                    goal.blue  = LVL_W'(LVL_MAX - (pos - BAND_STEPS) * WHEEL_SLOPE);
                end else if (pos < 3 * BAND_STEPS) begin
                    goal.green = LVL_MAX;
                    goal.blue  = '0;
                    goal.red   = LVL_W'((pos - 2 * BAND_STEPS) * WHEEL_SLOPE);
                end else if (pos < 4 * BAND_STEPS) begin
                    goal.red   = LVL_MAX;
                    goal.blue  = '0;
                    goal.green = LVL_W'(LVL_MAX - (pos - 3 * BAND_STEPS) * WHEEL_SLOPE);
                end else if (pos < 5 * BAND_STEPS) begin
                    goal.red   = LVL_MAX;
                    goal.green = '0;
                    goal.blue  = LVL_W'((pos - 4 * BAND_STEPS) * WHEEL_SLOPE);
                end else begin
                    goal.blue  = LVL_MAX;
                    goal.green = '0;
                    goal.red   = LVL_W'(LVL_MAX - (pos - 5 * BAND_STEPS) * WHEEL_SLOPE);
                end
                levels_q.red   = approach_level(levels_q.red, goal.red, delta_q);
                levels_q.green = approach_level(levels_q.green, goal.green, delta_q);
                levels_q.blue  = approach_level(levels_q.blue, goal.blue, delta_q);
            end
            OP_PWM: phase_q = phase_q + 8'd1;
            default: ;
        endcase
        res.red_on      = (phase_seen < levels_q.red);
        res.green_on    = (phase_seen < levels_q.green);
        res.blue_on     = (phase_seen < levels_q.blue);
        res.red_level   = levels_q.red;
        res.green_level = levels_q.green;
        res.blue_level  = levels_q.blue;
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item fresh;
        if (!i_rst_n) begin
            speed_q      = IDLE_SPEED_RST;
            delta_q      = SLEW_DELTA_RST;
            load_q       = LOAD_IDLE;
            silence_q    = '0;
            divider_q    = '0;
            hue_q        = '0;
            phase_q      = '0;
            levels_q     = '0;
            o_mismatches = 0;
            o_compared   = 0;
            led_drive_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_IDLE_SPEED: speed_q = i_cfg_data;
                    CFG_SLEW_DELTA: delta_q = i_cfg_data;
                    default: ;
                endcase
            end
            // the oldest expectation goes first, before this edge's input is added
            if (i_out_valid && !i_out_stall) begin
                if (led_drive_q.size() == 0) begin
                    $error("result transaction with no expectation waiting");
                    o_mismatches++;
                end else begin
                    want = led_drive_q.pop_front();
                    check_field("red_on", LVL_W'(want.red_on), LVL_W'(i_out_data.red_on));
                    check_field("green_on", LVL_W'(want.green_on),
                                LVL_W'(i_out_data.green_on));
                    check_field("blue_on", LVL_W'(want.blue_on), LVL_W'(i_out_data.blue_on));
                    check_field("red_level", want.red_level, i_out_data.red_level);
                    check_field("green_level", want.green_level, i_out_data.green_level);
                    check_field("blue_level", want.blue_level, i_out_data.blue_level);
                    o_compared++;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                advance_mixer(i_in_data, fresh);
                led_drive_q.push_back(fresh);
            end
        end
        o_pending = led_drive_q.size();
    end

endmodule

// ===== bench/usage_color_wheel_led_mixer_tb.sv =====
// top of the usage colour wheel led mixer bench: clock, reset, stimulus and verdict
// depends on ucwlm_pkg, usage_color_wheel_led_mixer and led_mixer_checker
`timescale 1ns / 1ps

module usage_color_wheel_led_mixer_tb
    import ucwlm_pkg::*;
;

    // opcode three has no meaning in the block; it must leave the state alone
    localparam logic [1:0] OP_UNUSED       = 2'd3;
    localparam int         SILENCE_RUN_LEN = 460;
    localparam int         HOLD_OFF_CYCLES = 300;
    localparam int         DRAIN_CYCLES    = 8;
    localparam int         CYCLE_LIMIT     = 800000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_in_item             i_in_data;
    logic                 o_out_valid;
    logic                 i_out_stall;
    t_out_item            o_out_data;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    int mismatch_total;
    int expected_left;
    int results_seen;

    // bookkeeping for the closing summary
    int  meaningful_sent = 0;
    int  set_sent        = 0;
    int  tick_sent       = 0;
    int  pwm_sent        = 0;
    int  unused_sent     = 0;
    int  settings_done   = 0;
    int  silent_run      = 0;
    int  longest_silence = 0;
    int  cycle_count     = 0;
    bit  quiet           = 1'b0;
    bit  hold_off_req    = 1'b0;

    // band boundaries of the colour wheel and either side of the idle threshold
    logic [LVL_W-1:0] band_edges [15] = '{8'd0, 8'd24, 8'd25, 8'd49, 8'd50, 8'd74, 8'd75,
                                          8'd99, 8'd100, 8'd124, 8'd125, 8'd149, 8'd150,
                                          8'd255, 8'd151};

    usage_color_wheel_led_mixer i_dut (.*);

    led_mixer_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (mismatch_total),
        .o_pending    (expected_left),
        .o_compared   (results_seen)
    );

    // 2 ns period
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // gap lengths: mostly none or short, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_opcode random_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return OP_SET_USAGE;
        if (r < 65) return OP_TICK;
        if (r < 95) return OP_PWM;
        return t_opcode'(OP_UNUSED);
    endfunction

    // half of the loads land on the wheel, some on a band boundary, the rest anywhere
    function automatic logic [LVL_W-1:0] random_usage();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return LVL_W'($urandom_range(0, HUE_WRAP));
        if (r < 65) return band_edges[$urandom_range(0, 14)];
        return LVL_W'($urandom);
    endfunction

    // one input transaction, entered and left at a falling edge; valid stays high
    // across back-to-back transactions and the payload holds while stalled
    task automatic offer_event(input t_opcode op, input logic [LVL_W-1:0] value);
        int       gap;
        t_in_item ev;
        gap            = quiet ? 0 : pick_gap();
        ev.opcode      = op;
        ev.usage_value = value;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= ev;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
        case (op)
            OP_SET_USAGE: begin
                set_sent++;
                silent_run = 0;
            end
            OP_TICK: begin
                tick_sent++;
                silent_run++;
                if (silent_run > longest_silence) longest_silence = silent_run;
            end
            OP_PWM: pwm_sent++;
            default: unused_sent++;
        endcase
        if (op != t_opcode'(OP_UNUSED)) meaningful_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // registers change only once the block has handed back every result
    task automatic apply_settings(input logic [CFG_W-1:0] speed, input logic [CFG_W-1:0] delta);
        i_in_valid <= 1'b0;
        while (expected_left != 0) @(negedge i_clk);
        write_reg(CFG_IDLE_SPEED, speed);
        write_reg(CFG_SLEW_DELTA, delta);
        i_cfg_valid <= 1'b0;
        settings_done++;
    endtask

    // one register setting followed by random bursts; a silence run first holds off
    // set-usage long enough for the silence counter to wrap and the idle hue to go round
    task automatic run_phase(input logic [CFG_W-1:0] speed, input logic [CFG_W-1:0] delta,
                             input int target, input bit silence_run, input bit hold_off);
        int start;
        int kind;
        apply_settings(speed, delta);
        start = meaningful_sent;
        if (silence_run) begin
            quiet = ($urandom_range(0, 1) == 1);
            offer_event(OP_SET_USAGE, LVL_W'($urandom_range(0, HUE_WRAP)));
            repeat (SILENCE_RUN_LEN) begin
                offer_event(($urandom_range(0, 19) == 0) ? OP_PWM : OP_TICK, LVL_W'($urandom));
            end
        end
        while (meaningful_sent - start < target) begin
            quiet = ($urandom_range(0, 4) == 0);
            // ask the result side for its long hold-off while items keep coming
            if (hold_off && meaningful_sent - start >= 40) begin
                hold_off_req = 1'b1;
                hold_off     = 1'b0;
            end
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                // mixed traffic
                repeat ($urandom_range(8, 30)) offer_event(random_op(), random_usage());
            end else if (kind < 85) begin
                // idle rotation: an idle load, then ticks with pwm steps between them
                offer_event(OP_SET_USAGE, LVL_W'($urandom_range(HUE_WRAP + 1, LVL_MAX)));
                repeat ($urandom_range(20, 60)) begin
                    offer_event(($urandom_range(0, 3) == 0) ? OP_PWM : OP_TICK,
                                LVL_W'($urandom));
                end
            end else begin
                // phase sweep across the current levels
                repeat ($urandom_range(20, 60)) offer_event(OP_PWM, LVL_W'($urandom));
            end
        end
    endtask

    // result side: random stalls, long free stretches now and then, and one long
    // hold-off on request so that both registers in the block fill up
    initial begin : result_side
        int stall_len;
        int free_len;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall_len    = HOLD_OFF_CYCLES;
            end else begin
                stall_len = pick_gap();
            end
            if (stall_len > 0) begin
                i_out_stall <= 1'b1;
                repeat (stall_len) @(negedge i_clk);
            end
            free_len = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 4);
            i_out_stall <= 1'b0;
            repeat (free_len) @(negedge i_clk);
        end
    end

    // watchdog
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timed out after %0d cycles with %0d results outstanding",
                 cycle_count, expected_left);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : stimulus
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_IDLE_SPEED;
        i_cfg_data  = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: pwm on dark levels, a tick on the idle load, the unused opcode
        offer_event(OP_PWM, '0);
        offer_event(OP_TICK, LVL_MAX);
        offer_event(t_opcode'(OP_UNUSED), LVL_MAX);

        // zero idle speed and full slew, so each tick lands on the wheel target at once;
        // then every band start, the top of the wheel and just past it
        apply_settings('0, LVL_MAX);
        for (int k = 0; k < 15; k += 2) begin
            offer_event(OP_SET_USAGE, band_edges[k]);
            offer_event(OP_TICK, band_edges[k]);
        end
        offer_event(OP_PWM, '0);
        offer_event(OP_PWM, LVL_MAX);

        // random part across several settings, extremes and zeros among them
        run_phase(8'd1, LVL_MAX, 500, 1'b1, 1'b0);
        run_phase(LVL_MAX, 8'd1, 300, 1'b0, 1'b1);
        run_phase('0, '0, 150, 1'b0, 1'b0);
        run_phase(CFG_W'($urandom_range(2, 20)), CFG_W'($urandom_range(2, 40)),
                  250, 1'b0, 1'b0);
        run_phase(IDLE_SPEED_RST, SLEW_DELTA_RST, 250, 1'b0, 1'b0);
        run_phase(CFG_W'($urandom_range(100, 254)), CFG_W'($urandom_range(41, 254)),
                  150, 1'b0, 1'b0);

        // drain
        i_in_valid <= 1'b0;
        while (expected_left != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("covered %0d transactions: %0d set-usage, %0d tick, %0d pwm, %0d unused opcode",
                 set_sent + tick_sent + pwm_sent + unused_sent, set_sent, tick_sent, pwm_sent,
                 unused_sent);
        $display("%0d results compared over %0d register settings, longest silent run %0d ticks",
                 results_seen, settings_done, longest_silence);
        if (mismatch_total == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ucwlm_pkg.sv
rtl/ucwlm_wheel.sv
rtl/usage_color_wheel_led_mixer.sv
bench/led_mixer_checker.sv
bench/usage_color_wheel_led_mixer_tb.sv
